[rtl/core/rctm_pkg.sv]
// Shared constants, types and per-channel tick logic for the root counter timers.
`timescale 1ns / 1ps
`default_nettype none

package rctm_pkg;

    localparam int unsigned NUM_CH = 6;

    localparam logic [11:0] HBLANK_DIVIDE = 12'd2343;
    localparam logic [11:0] PIXEL_DIVIDE  = 12'd3;

    localparam logic [31:0] BANK_A = 32'h1F80_1100;
    localparam logic [31:0] BANK_B = 32'h1F80_1480;

    // request kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // register select within a channel slot (address bits 3:2)
    localparam logic [1:0] REG_COUNT  = 2'd0;
    localparam logic [1:0] REG_MODE   = 2'd1;
    localparam logic [1:0] REG_TARGET = 2'd2;

    // mode bit positions
    localparam int unsigned M_RESET_TGT = 3;
    localparam int unsigned M_IRQ_TGT   = 4;
    localparam int unsigned M_IRQ_OVF   = 5;
    localparam int unsigned M_REPEAT    = 6;
    localparam int unsigned M_TOGGLE    = 7;
    localparam int unsigned M_ALT       = 8;
    localparam int unsigned M_PRE2      = 9;
    localparam int unsigned M_IRQ_EN    = 10;
    localparam int unsigned M_TGT_FLAG  = 11;
    localparam int unsigned M_OVF_FLAG  = 12;
    localparam int unsigned M_PRE45_LO  = 13;
    localparam int unsigned M_PRE45_HI  = 14;

    typedef logic [14:0] mode_t;

    localparam mode_t MODE_WRITABLE = 15'h63FF;
    localparam mode_t MODE_RESET    = 15'h0400;

    typedef struct packed {
        logic        hit;
        logic [2:0]  ch;
        logic [1:0]  sel;
        logic [1:0]  off;
        logic [31:0] fmask;
    } bus_dec_t;

    typedef struct packed {
        logic [31:0] count;
        mode_t       mode;
        logic [11:0] phase;
        logic        pulse;
    } tick_t;

    function automatic logic [31:0] width_mask(input logic [2:0] ch);
        return (ch < 3'd3) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
    endfunction

    function automatic logic [11:0] rate_of(input logic [2:0] ch, input mode_t m);
        logic [11:0] rate;
        rate = 12'd1;
        unique case (ch)
            3'd0:        rate = m[M_ALT] ? PIXEL_DIVIDE : 12'd1;
            3'd1, 3'd3:  rate = m[M_ALT] ? HBLANK_DIVIDE : 12'd1;
            3'd2:        rate = m[M_PRE2] ? 12'd8 : 12'd1;
            3'd4, 3'd5: begin
                unique case (m[M_PRE45_HI:M_PRE45_LO])
                    2'd1:    rate = 12'd8;
                    2'd2:    rate = 12'd16;
                    2'd3:    rate = 12'd256;
                    default: rate = 12'd1;
                endcase
            end
            default:     rate = 12'd1;
        endcase
        return rate;
    endfunction

    // One tick of one channel: prescale, step, flags and interrupt.
    function automatic tick_t tick_chan(
        input logic [2:0]  ch,
        input logic [31:0] count,
        input mode_t       mode,
        input logic [31:0] target,
        input logic [11:0] phase
    );
        logic [11:0] rate;
        logic [11:0] p1;
        logic [31:0] maxv;
        logic [31:0] cur;
        logic [31:0] nxt;
        mode_t       m;
        tick_t       r;
        rate    = rate_of(ch, mode);
        p1      = phase + 12'd1;
        maxv    = width_mask(ch);
        cur     = count & maxv;
        nxt     = cur;
        m       = mode;
        r.pulse = 1'b0;
        r.count = count;
        r.phase = p1;
        if (p1 >= rate) begin
            r.phase = p1 - rate;
            if (cur == maxv) begin
                nxt = 32'd0;
                m[M_OVF_FLAG] = 1'b1;
                if (m[M_IRQ_OVF] && m[M_IRQ_EN]) begin
                    r.pulse = 1'b1;
                    // one-shot and toggle both drop the enable after firing
                    if (!m[M_REPEAT] || m[M_TOGGLE]) begin
                        m[M_IRQ_EN] = 1'b0;
                    end
                end
            end else begin
                nxt = cur + 32'd1;
            end
            if (nxt == (target & maxv)) begin
                m[M_TGT_FLAG] = 1'b1;
                if (m[M_IRQ_TGT] && m[M_IRQ_EN]) begin
                    r.pulse = 1'b1;
                    if (!m[M_REPEAT] || m[M_TOGGLE]) begin
                        m[M_IRQ_EN] = 1'b0;
                    end
                end
                if (m[M_RESET_TGT]) begin
                    nxt = 32'd0;
                end
            end
            r.count = nxt;
        end
        r.mode = m;
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/six_channel_root_counter_timers_core.sv]
// Top level of the six-channel root counter timer block with stream ports.
`timescale 1ns / 1ps
`default_nettype none

// Six counter channels (0..2 are 16 bits, 3..5 are 32 bits) behind a stream port.
// Each request is a tick (tuser 0), a bus read (1) or a bus write (2);
// every request yields exactly one response carrying read data, a decode hit flag
// and the per-channel interrupt pulses of that tick. The block takes one request
// per clock while the response is not stalled: the request sits in the
// request register, and when it advances the decode, register update and
// tick logic settle into the response register. A stalled response holds while
// the request register still takes one more request.
module six_channel_root_counter_timers_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] address, [34:32] size_bytes, [66:35] write_data, [71:67] zero
    input  logic [71:0] s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] read_data, [32] hit, [38:33] irq_pulses, [39] zero
    output logic [39:0] m_axis_tdata
);
    import rctm_pkg::*;

    logic        in_valid_reg;
    logic [1:0]  in_kind_reg;
    logic [31:0] in_addr_reg;
    logic [2:0]  in_size_reg;
    logic [31:0] in_wdata_reg;

    logic        out_valid_reg;
    logic [39:0] out_data_reg;

    logic        advance;
    logic        s_accept;
    bus_dec_t    dec;
    logic [31:0] read_data;
    logic [5:0]  irq_pulses;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    rctm_decode u_decode (
        .kind       (in_kind_reg),
        .address    (in_addr_reg),
        .size_bytes (in_size_reg),
        .dec        (dec)
    );

    rctm_bank u_bank (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .kind       (in_kind_reg),
        .dec        (dec),
        .write_data (in_wdata_reg),
        .read_data  (read_data),
        .irq_pulses (irq_pulses)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_kind_reg  <= s_axis_tuser;
            in_addr_reg  <= s_axis_tdata[31:0];
            in_size_reg  <= s_axis_tdata[34:32];
            in_wdata_reg <= s_axis_tdata[66:35];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {1'b0, irq_pulses, dec.hit, read_data};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

[rtl/core/rctm_decode.sv]
// Bus address decoder: bank, channel, register slot, byte offset and lane mask.
`timescale 1ns / 1ps
`default_nettype none

module rctm_decode (
    input  logic [1:0]         kind,
    input  logic [31:0]        address,
    input  logic [2:0]         size_bytes,
    output rctm_pkg::bus_dec_t dec
);
    import rctm_pkg::*;

    logic        in_a;
    logic        in_b;
    logic        slot_ok;
    logic        size_ok;
    logic        is_bus;
    logic [31:0] fmask;

    assign in_a    = (address[31:6] == BANK_A[31:6]) && (address[5:4] != 2'b11);
    assign in_b    = (address[31:6] == BANK_B[31:6]) && (address[5:4] != 2'b11);
    assign slot_ok = (address[3:2] != 2'b11);
    assign is_bus  = (kind == KIND_READ) || (kind == KIND_WRITE);

    always_comb begin
        size_ok = 1'b0;
        fmask   = 32'd0;
        unique case (size_bytes)
            3'd1: begin
                size_ok = 1'b1;
                fmask   = 32'h0000_00FF;
            end
            3'd2: begin
                size_ok = (address[1:0] != 2'b11);
                fmask   = 32'h0000_FFFF;
            end
            3'd4: begin
                size_ok = (address[1:0] == 2'b00);
                fmask   = 32'hFFFF_FFFF;
            end
            default: begin
                size_ok = 1'b0;
                fmask   = 32'd0;
            end
        endcase
    end

    assign dec = '{
        hit:   is_bus && (in_a || in_b) && slot_ok && size_ok,
        ch:    in_b ? ({1'b0, address[5:4]} + 3'd3) : {1'b0, address[5:4]},
        sel:   address[3:2],
        off:   address[1:0],
        fmask: fmask
    };

endmodule

`default_nettype wire

[rtl/core/rctm_bank.sv]
// Timer register bank: count, mode, target and prescale phase for six channels.
`timescale 1ns / 1ps
`default_nettype none

module rctm_bank (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic [1:0]         kind,
    input  rctm_pkg::bus_dec_t dec,
    input  logic [31:0]        write_data,
    output logic [31:0]        read_data,
    output logic [5:0]         irq_pulses
);
    import rctm_pkg::*;

    logic [31:0] count_reg  [NUM_CH];
    logic [31:0] count_next [NUM_CH];
    mode_t       mode_reg   [NUM_CH];
    mode_t       mode_next  [NUM_CH];
    logic [31:0] target_reg [NUM_CH];
    logic [31:0] target_next[NUM_CH];
    logic [11:0] phase_reg  [NUM_CH];
    logic [11:0] phase_next [NUM_CH];

    tick_t       tick_res   [NUM_CH];
    logic [5:0]  pulses;
    logic [31:0] cur_val;
    logic [31:0] wmask;
    logic [31:0] lane;
    logic [31:0] wval;
    logic [4:0]  shift;

    for (genvar i = 0; i < NUM_CH; i++) begin : g_tick
        assign tick_res[i] = tick_chan(3'(i), count_reg[i], mode_reg[i],
                                       target_reg[i], phase_reg[i]);
        assign pulses[i]   = tick_res[i].pulse;
    end

    assign wmask = width_mask(dec.ch);
    assign shift = {dec.off, 3'b000};

    always_comb begin
        cur_val = 32'd0;
        for (int i = 0; i < NUM_CH; i++) begin
            if (dec.ch == 3'(i)) begin
                unique case (dec.sel)
                    REG_COUNT:  cur_val = count_reg[i] & wmask;
                    REG_MODE:   cur_val = {17'd0, mode_reg[i]};
                    default:    cur_val = target_reg[i] & wmask;
                endcase
            end
        end
    end

    // merge the new bytes into the current register value
    assign lane = dec.fmask << shift;
    assign wval = (cur_val & ~lane) | ((write_data << shift) & lane);

    assign read_data  = (kind == KIND_READ && dec.hit) ? ((cur_val >> shift) & dec.fmask)
                                                       : 32'd0;
    assign irq_pulses = (kind == KIND_TICK) ? pulses : 6'd0;

    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            count_next[i]  = count_reg[i];
            mode_next[i]   = mode_reg[i];
            target_next[i] = target_reg[i];
            phase_next[i]  = phase_reg[i];
            if (kind == KIND_TICK) begin
                count_next[i] = tick_res[i].count;
                mode_next[i]  = tick_res[i].mode;
                phase_next[i] = tick_res[i].phase;
            end else if (kind == KIND_WRITE && dec.hit && dec.ch == 3'(i)) begin
                unique case (dec.sel)
                    REG_COUNT: begin
                        count_next[i] = wval & wmask;
                        phase_next[i] = 12'd0;
                    end
                    REG_MODE: begin
                        // keep sticky flags, re-arm the interrupt, restart the count
                        mode_next[i] = (wval[14:0] & MODE_WRITABLE)
                                     | (mode_reg[i] & ((15'd1 << M_TGT_FLAG)
                                                     | (15'd1 << M_OVF_FLAG)))
                                     | (15'd1 << M_IRQ_EN);
                        count_next[i] = 32'd0;
                        phase_next[i] = 12'd0;
                    end
                    default: begin
                        target_next[i] = wval & wmask;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_CH; i++) begin
            if (!aresetn) begin
                count_reg[i]  <= 32'd0;
                mode_reg[i]   <= MODE_RESET;
                target_reg[i] <= 32'd0;
                phase_reg[i]  <= 12'd0;
            end else if (advance) begin
                count_reg[i]  <= count_next[i];
                mode_reg[i]   <= mode_next[i];
                target_reg[i] <= target_next[i];
                phase_reg[i]  <= phase_next[i];
            end
        end
    end

endmodule

`default_nettype wire
